// ===== sv/sacfp_pkg.sv =====
// sacfp_pkg: shared types, sizes and helpers for the set-associative cache
// with FIFO replacement and next-block prefetch. No dependencies.
package sacfp_pkg;

    localparam int ADDR_BITS    = 48;
    localparam int MAX_SET_BITS = 8;
    localparam int MAX_WAYS     = 8;

    localparam int SET_W    = MAX_SET_BITS;
    localparam int NUM_SETS = 1 << SET_W;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W    = $clog2(MAX_WAYS + 1);
    localparam int LINE_W   = SET_W + WAY_W;
    localparam int NUM_LINES = 1 << LINE_W;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // config register indexes (paddr[3:2])
    localparam logic [1:0] REG_PREFETCH = 2'd0;
    localparam logic [1:0] REG_OFFSET   = 2'd1;
    localparam logic [1:0] REG_SETS     = 2'd2;
    localparam logic [1:0] REG_WAYS     = 2'd3;

    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [ADDR_BITS-1:0] address;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic        prefetched;
        logic [31:0] read_count;
        logic [31:0] write_count;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
    } t_out_item;

    // effective configuration, already clamped
    typedef struct packed {
        logic             pf_en;
        logic [3:0]       ob;
        logic [3:0]       sb;
        logic [CNT_W-1:0] ways;
    } t_cfg;

    // per-set state: valid prefix length and FIFO pointer
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [WAY_W-1:0] ptr;
    } t_meta;

    typedef struct packed {
        logic             rd;
        logic             wr;
        logic [SET_W-1:0] set;
        t_meta            meta;
    } t_meta_req;

    typedef struct packed {
        logic                 rd;
        logic                 wr;
        logic [SET_W-1:0]     set;
        logic [WAY_W-1:0]     way;
        logic [ADDR_BITS-1:0] tag;
    } t_tag_req;

    typedef struct packed {
        logic [SET_W-1:0]     set;
        logic [ADDR_BITS-1:0] tag;
    } t_split;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MRD,
        S_MCAP,
        S_TRD,
        S_TCMP,
        S_FILL,
        S_DONE
    } t_state;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

    function automatic t_split split_addr(input logic [ADDR_BITS-1:0] a,
                                          input logic [3:0] ob,
                                          input logic [3:0] sb);
        logic [ADDR_BITS-1:0] shifted;
        logic [SET_W:0]       mask;
        logic [4:0]           sh;
        t_split               r;
        shifted = a >> ob;
        mask    = ((SET_W+1)'(1) << sb) - (SET_W+1)'(1);
        sh      = {1'b0, ob} + {1'b0, sb};
        r.set   = shifted[SET_W-1:0] & mask[SET_W-1:0];
        r.tag   = a >> sh;
        split_addr = r;
    endfunction

endpackage

// ===== sv/sacfp_regs.sv =====
// sacfp_regs: APB configuration registers and their clamped effective values.
// Depends on sacfp_pkg.
module sacfp_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sacfp_pkg::PADDR_W-1:0]  paddr,
    input  logic [sacfp_pkg::PDATA_W-1:0]  pwdata,
    output logic [sacfp_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    output sacfp_pkg::t_cfg                o_cfg
);
    import sacfp_pkg::*;

    logic       r_pf_en;
    logic [3:0] r_ob;
    logic [3:0] r_sb;
    logic [3:0] r_ways;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pf_en <= 1'b0;
            r_ob    <= 4'd6;
            r_sb    <= 4'd6;
            r_ways  <= 4'd8;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PREFETCH: r_pf_en <= pwdata[0];
                REG_OFFSET:   r_ob    <= pwdata[3:0];
                REG_SETS:     r_sb    <= pwdata[3:0];
                REG_WAYS:     r_ways  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PREFETCH: prdata = PDATA_W'(r_pf_en);
            REG_OFFSET:   prdata = PDATA_W'(r_ob);
            REG_SETS:     prdata = PDATA_W'(r_sb);
            REG_WAYS:     prdata = PDATA_W'(r_ways);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.pf_en = r_pf_en;
        o_cfg.ob    = r_ob;
        o_cfg.sb    = (r_sb > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : r_sb;
        if (r_ways == 4'd0)
            o_cfg.ways = CNT_W'(1);
        else if (r_ways > 4'(MAX_WAYS))
            o_cfg.ways = CNT_W'(MAX_WAYS);
        else
            o_cfg.ways = CNT_W'(r_ways);
    end

endmodule

// ===== sv/sacfp_set_state.sv =====
// sacfp_set_state: per-set fill count and FIFO pointer memory, with one
// valid flop per set so that untouched sets read as empty. Depends on sacfp_pkg.
module sacfp_set_state (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sacfp_pkg::t_meta_req i_req,
    output sacfp_pkg::t_meta     o_meta
);
    import sacfp_pkg::*;

    t_meta                mem [NUM_SETS];
    logic [NUM_SETS-1:0]  r_row_vld;
    t_meta                r_q;
    logic                 r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr)
            mem[i_req.set] <= i_req.meta;
        if (i_req.rd)
            r_q <= mem[i_req.set];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_q_vld   <= 1'b0;
        end else begin
            if (i_req.wr)
                r_row_vld[i_req.set] <= 1'b1;
            if (i_req.rd)
                r_q_vld <= r_row_vld[i_req.set];
        end
    end

    assign o_meta = r_q_vld ? r_q : '0;

endmodule

// ===== sv/sacfp_tag_store.sv =====
// sacfp_tag_store: tag memory, one way per access, plus the shared tag
// comparator used for every way of every lookup. Depends on sacfp_pkg.
module sacfp_tag_store (
    input  logic                i_clk,
    input  sacfp_pkg::t_tag_req i_req,
    output logic                o_match
);
    import sacfp_pkg::*;

    logic [ADDR_BITS-1:0] mem [NUM_LINES];
    logic [ADDR_BITS-1:0] r_q;
    logic [ADDR_BITS-1:0] r_cmp_tag;

    always_ff @(posedge i_clk) begin
        if (i_req.wr)
            mem[{i_req.set, i_req.way}] <= i_req.tag;
        if (i_req.rd) begin
            r_q       <= mem[{i_req.set, i_req.way}];
            r_cmp_tag <= i_req.tag;
        end
    end

    assign o_match = (r_q == r_cmp_tag);

endmodule

// ===== sv/sacfp_seq.sv =====
// sacfp_seq: access sequencer. Walks the ways of the demand set and, after a demand
// miss with prefetch enabled, the prefetch set through the shared tag comparator, installs
// on a miss, keeps the saturating totals and the output register. Depends on sacfp_pkg.
module sacfp_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sacfp_pkg::t_cfg      i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sacfp_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sacfp_pkg::t_out_item o_out_data,
    output sacfp_pkg::t_meta_req o_meta_req,
    input  sacfp_pkg::t_meta     i_meta,
    output sacfp_pkg::t_tag_req  o_tag_req,
    input  logic                 i_tag_match
);
    import sacfp_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic                 r_phase;
    logic                 r_out_valid;
    logic [31:0]          r_read_total;
    logic [31:0]          r_write_total;
    logic [31:0]          r_hit_total;
    logic [31:0]          r_miss_total;

    logic                 r_hit;
    logic                 r_pf;
    logic [SET_W-1:0]     r_cur_set;
    logic [ADDR_BITS-1:0] r_cur_tag;
    logic [ADDR_BITS-1:0] r_next;
    logic [CNT_W-1:0]     r_cnt;
    logic [WAY_W-1:0]     r_ptr;
    logic [CNT_W-1:0]     r_limit;
    logic [WAY_W-1:0]     r_way;
    t_out_item            r_out_data;

    logic                 accept;
    logic                 out_free;
    logic                 more_ways;
    logic [CNT_W-1:0]     meta_limit;
    logic [ADDR_BITS-1:0] split_in;
    t_split               split;
    logic [WAY_W-1:0]     fifo_way;
    logic [WAY_W-1:0]     victim;
    t_meta                new_meta;

    assign accept   = i_in_valid & ~o_in_stall;
    assign out_free = ~r_out_valid | ~i_out_stall;
    assign more_ways = (CNT_W'(r_way) + CNT_W'(1)) < r_limit;
    assign meta_limit = (i_meta.cnt < i_cfg.ways) ? i_meta.cnt : i_cfg.ways;

    // one shifter splits both the demand address and the next-block address
    assign split_in = (r_state == S_IDLE) ? i_in_data.address : r_next;
    assign split    = split_addr(split_in, i_cfg.ob, i_cfg.sb);

    // victim: lowest invalid way, else the FIFO pointer (way 0 if out of range)
    always_comb begin
        fifo_way = (CNT_W'(r_ptr) >= i_cfg.ways) ? '0 : r_ptr;
        if (r_cnt < i_cfg.ways) begin
            victim       = r_cnt[WAY_W-1:0];
            new_meta.cnt = r_cnt + CNT_W'(1);
            new_meta.ptr = r_ptr;
        end else begin
            victim       = fifo_way;
            new_meta.cnt = r_cnt;
            new_meta.ptr = ((CNT_W'(fifo_way) + CNT_W'(1)) == i_cfg.ways) ?
                           '0 : fifo_way + WAY_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_MRD;
            S_MRD:  n_state = S_MCAP;
            S_MCAP: n_state = (meta_limit == '0) ? S_FILL : S_TRD;
            S_TRD:  n_state = S_TCMP;
            S_TCMP: begin
                if (i_tag_match)
                    n_state = S_DONE;
                else if (more_ways)
                    n_state = S_TRD;
                else
                    n_state = S_FILL;
            end
            S_FILL: n_state = (!r_phase && i_cfg.pf_en) ? S_MRD : S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        o_meta_req.rd   = (r_state == S_MRD);
        o_meta_req.wr   = (r_state == S_FILL);
        o_meta_req.set  = r_cur_set;
        o_meta_req.meta = new_meta;
        o_tag_req.rd    = (r_state == S_TRD);
        o_tag_req.wr    = (r_state == S_FILL);
        o_tag_req.set   = r_cur_set;
        o_tag_req.way   = (r_state == S_FILL) ? victim : r_way;
        o_tag_req.tag   = r_cur_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_read_total  <= '0;
            r_write_total <= '0;
            r_hit_total   <= '0;
            r_miss_total  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free)
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_phase <= 1'b0;
                    if (accept && i_in_data.action == ACT_WRITE)
                        r_write_total <= sat_inc(r_write_total);
                end
                S_TCMP: begin
                    if (i_tag_match && !r_phase)
                        r_hit_total <= sat_inc(r_hit_total);
                end
                S_FILL: begin
                    r_read_total <= sat_inc(r_read_total);
                    if (!r_phase) begin
                        r_miss_total <= sat_inc(r_miss_total);
                        if (i_cfg.pf_en)
                            r_phase <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_hit     <= 1'b0;
                    r_pf      <= 1'b0;
                    r_cur_set <= split.set;
                    r_cur_tag <= split.tag;
                    r_next    <= i_in_data.address + (ADDR_BITS'(1) << i_cfg.ob);
                end
            end
            S_MCAP: begin
                r_cnt   <= i_meta.cnt;
                r_ptr   <= i_meta.ptr;
                r_limit <= meta_limit;
                r_way   <= '0;
            end
            S_TCMP: begin
                if (i_tag_match && !r_phase)
                    r_hit <= 1'b1;
                if (!i_tag_match)
                    r_way <= r_way + WAY_W'(1);
            end
            S_FILL: begin
                if (r_phase) begin
                    r_pf <= 1'b1;
                end else if (i_cfg.pf_en) begin
                    r_cur_set <= split.set;
                    r_cur_tag <= split.tag;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_data.hit         <= r_hit;
                    r_out_data.prefetched  <= r_pf;
                    r_out_data.read_count  <= r_read_total;
                    r_out_data.write_count <= r_write_total;
                    r_out_data.hit_count   <= r_hit_total;
                    r_out_data.miss_count  <= r_miss_total;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_MRD))
        else $error("accepted transfer did not start a lookup");

    a_way_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRD) |-> (CNT_W'(r_way) < r_limit))
        else $error("way walk beyond valid ways");

    a_hit_no_pf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !(r_hit && r_pf))
        else $error("prefetch reported on a demand hit");

    a_pf_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> i_cfg.pf_en)
        else $error("prefetch lookup with prefetch disabled");

    a_reads_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_total >= $past(r_read_total))
        else $error("read total went backward");
`endif

endmodule

// ===== sv/set_assoc_cache_fifo_prefetch_unit.sv =====
// Sequence: accept, fetch the set state, read and compare the valid ways one by one until a match,
// install on a miss, the same again for the prefetch set after a demand miss with prefetch
// enabled, and load the output register once the output is not stalled.
// Throughput: one transfer at a time; the next can be taken in the cycle after the
// result is registered. The single tag-memory port and comparator set the pace.
// Reset: config to defaults, totals zero, all sets empty at once; no clear pass.
module set_assoc_cache_fifo_prefetch_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sacfp_pkg::PADDR_W-1:0]  paddr,
    input  logic [sacfp_pkg::PDATA_W-1:0]  pwdata,
    output logic [sacfp_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sacfp_pkg::t_in_item            i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sacfp_pkg::t_out_item           o_out_data
);
    import sacfp_pkg::*;

    t_cfg      cfg;
    t_meta_req meta_req;
    t_meta     meta;
    t_tag_req  tag_req;
    logic      tag_match;

    sacfp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sacfp_set_state u_set_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (meta_req),
        .o_meta  (meta)
    );

    sacfp_tag_store u_tag_store (
        .i_clk   (i_clk),
        .i_req   (tag_req),
        .o_match (tag_match)
    );

    sacfp_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_meta_req  (meta_req),
        .i_meta      (meta),
        .o_tag_req   (tag_req),
        .i_tag_match (tag_match)
    );

endmodule

// ===== tb/sv/set_assoc_cache_fifo_prefetch_unit_test.sv =====
// Self-checking testbench for set_assoc_cache_fifo_prefetch_unit: directed table, then random
// access phases under changing APB settings, all checked against an in-bench cache predictor.
// Depends on sacfp_pkg and the unit under test.
module set_assoc_cache_fifo_prefetch_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sacfp_pkg::*;

    localparam logic ACT_READ     = ~ACT_WRITE;
    localparam int   PHASES       = 10;
    localparam int   PHASE_ITEMS  = 125;
    localparam int   POOL_SIZE    = 24;
    localparam int   IDLE_PCT     = 25;
    localparam int   QUIET_PHASE  = 5;
    localparam int   DRAIN_CYCLES = 60;

    localparam logic [1:0] ALL_REGS [4] = '{REG_PREFETCH, REG_OFFSET, REG_SETS, REG_WAYS};

    typedef enum logic [1:0] {
        ROW_SET_REG,
        ROW_GET_REG,
        ROW_ACCESS
    } t_row_kind;

    // value: write data, or expected read data; hit/prefetched only used when typed
    typedef struct packed {
        t_row_kind            kind;
        logic [1:0]           idx;
        logic [31:0]          value;
        logic                 action;
        logic [ADDR_BITS-1:0] address;
        logic                 typed;
        logic                 hit;
        logic                 prefetched;
    } t_row;

    localparam int NUM_ROWS = 30;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        // reset values
        '{ROW_GET_REG, REG_PREFETCH, 32'd0, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        '{ROW_GET_REG, REG_OFFSET, 32'd6, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        '{ROW_GET_REG, REG_SETS, 32'd6, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        '{ROW_GET_REG, REG_WAYS, 32'd8, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        // cold miss, then a hit in the same block
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_READ, 48'h0, 1'b1, 1'b0, 1'b0},
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_WRITE, 48'h3F, 1'b1, 1'b1, 1'b0},
        '{ROW_SET_REG, REG_PREFETCH, 32'd1, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        // next block wraps to block 0, already present
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_WRITE, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0},
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_READ, 48'h40, 1'b1, 1'b0, 1'b1},
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_READ, 48'h80, 1'b1, 1'b1, 1'b0},
        // zero ways acts as one, one set: prefetch evicts the demand block
        '{ROW_SET_REG, REG_WAYS, 32'd0, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        '{ROW_SET_REG, REG_SETS, 32'd0, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_READ, 48'h4_0000, 1'b1, 1'b0, 1'b1},
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_READ, 48'h4_0000, 1'b1, 1'b0, 1'b1},
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_WRITE, 48'h4_0040, 1'b1, 1'b1, 1'b0},
        // wrap to an absent block 0
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_READ, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1},
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_READ, 48'h0, 1'b1, 1'b1, 1'b0},
        // byte blocks, set and way counts above their maximum
        '{ROW_SET_REG, REG_OFFSET, 32'd0, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        '{ROW_SET_REG, REG_SETS, 32'd15, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        '{ROW_SET_REG, REG_WAYS, 32'd15, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_READ, 48'h123, 1'b0, 1'b0, 1'b0},
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_WRITE, 48'h124, 1'b0, 1'b0, 1'b0},
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_READ, 48'h125, 1'b0, 1'b0, 1'b0},
        '{ROW_SET_REG, REG_OFFSET, 32'd12, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_WRITE, 48'h8000_0000_0000, 1'b0, 1'b0, 1'b0},
        '{ROW_ACCESS, REG_PREFETCH, 32'd0, ACT_READ, 48'h8000_0000_1000, 1'b0, 1'b0, 1'b0},
        '{ROW_GET_REG, REG_PREFETCH, 32'd1, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        '{ROW_GET_REG, REG_OFFSET, 32'd12, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        '{ROW_GET_REG, REG_SETS, 32'd15, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0},
        '{ROW_GET_REG, REG_WAYS, 32'd15, ACT_READ, 48'h0, 1'b0, 1'b0, 1'b0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;

    bit                   quiet = 1'b0;
    int                   mismatches = 0;
    t_out_item            pending_results [$];

    // predictor state
    logic                 cfg_pf;
    logic [3:0]           cfg_ob;
    logic [3:0]           cfg_sb;
    logic [3:0]           cfg_ways;
    logic                 line_ok [NUM_SETS][MAX_WAYS];
    logic [ADDR_BITS-1:0] line_tag_mem [NUM_SETS][MAX_WAYS];
    logic [WAY_W-1:0]     fifo_ptr [NUM_SETS];
    logic [31:0]          total_reads;
    logic [31:0]          total_writes;
    logic [31:0]          total_hits;
    logic [31:0]          total_misses;

    logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];
    logic [ADDR_BITS-1:0] stream_addr;

    set_assoc_cache_fifo_prefetch_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic int ways_active();
        if (cfg_ways == 4'd0) return 1;
        return (cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways);
    endfunction

    function automatic bit tag_present(int set_idx, logic [ADDR_BITS-1:0] tag);
        int n;
        n = ways_active();
        for (int w = 0; w < n; w++) begin
            if (line_ok[set_idx][w] && line_tag_mem[set_idx][w] == tag) return 1'b1;
        end
        return 1'b0;
    endfunction

    // lowest empty way first, else the set's FIFO victim
    function automatic void fill_line(int set_idx, logic [ADDR_BITS-1:0] tag);
        int n;
        int p;
        n = ways_active();
        for (int w = 0; w < n; w++) begin
            if (!line_ok[set_idx][w]) begin
                line_ok[set_idx][w] = 1'b1;
                line_tag_mem[set_idx][w] = tag;
                return;
            end
        end
        p = int'(fifo_ptr[set_idx]);
        if (p >= n) p = 0;  // pointer left beyond a shrunk way count
        line_tag_mem[set_idx][p] = tag;
        fifo_ptr[set_idx] = WAY_W'((p + 1) % n);
    endfunction

    function automatic t_out_item cache_access(logic action, logic [ADDR_BITS-1:0] address);
        int                   sb;
        int                   set_idx;
        int                   nset;
        logic [ADDR_BITS-1:0] smask;
        logic [ADDR_BITS-1:0] tag;
        logic [ADDR_BITS-1:0] nxt;
        logic [ADDR_BITS-1:0] ntag;
        t_out_item            r;
        sb      = (cfg_sb > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_sb);
        smask   = (ADDR_BITS'(1) << sb) - ADDR_BITS'(1);
        set_idx = int'((address >> cfg_ob) & smask);
        tag     = address >> (int'(cfg_ob) + sb);
        r       = '0;
        if (action == ACT_WRITE) total_writes = bump(total_writes);
        r.hit = tag_present(set_idx, tag);
        if (r.hit) begin
            total_hits = bump(total_hits);
        end else begin
            total_misses = bump(total_misses);
            total_reads  = bump(total_reads);
            fill_line(set_idx, tag);
            if (cfg_pf) begin
                nxt  = address + (ADDR_BITS'(1) << cfg_ob);  // wraps at the address width
                nset = int'((nxt >> cfg_ob) & smask);
                ntag = nxt >> (int'(cfg_ob) + sb);
                if (!tag_present(nset, ntag)) begin
                    total_reads = bump(total_reads);
                    fill_line(nset, ntag);
                    r.prefetched = 1'b1;
                end
            end
        end
        r.read_count  = total_reads;
        r.write_count = total_writes;
        r.hit_count   = total_hits;
        r.miss_count  = total_misses;
        return r;
    endfunction

    function automatic logic [31:0] cfg_value(logic [1:0] idx);
        case (idx)
            REG_PREFETCH: return {31'd0, cfg_pf};
            REG_OFFSET:   return {28'd0, cfg_ob};
            REG_SETS:     return {28'd0, cfg_sb};
            default:      return {28'd0, cfg_ways};
        endcase
    endfunction

    function automatic logic [31:0] with_noise(logic [31:0] v, logic [31:0] field_mask);
        return ($urandom & ~field_mask) | (v & field_mask);
    endfunction

    function automatic logic [ADDR_BITS-1:0] pick_address();
        int                   pick;
        logic [ADDR_BITS-1:0] blk;
        logic [ADDR_BITS-1:0] a;
        blk  = ADDR_BITS'(1) << cfg_ob;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            a = addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                + blk * ADDR_BITS'($urandom_range(0, 3))
                + (ADDR_BITS'($urandom) & (blk - ADDR_BITS'(1)));
            if ($urandom_range(0, 3) == 0) stream_addr = a;
            return a;
        end
        if (pick < 70) begin
            stream_addr = stream_addr + blk;
            return stream_addr;
        end
        if (pick < 90) return ADDR_BITS'({$urandom, $urandom});
        return '1 - blk * ADDR_BITS'($urandom_range(0, 3));
    endfunction

    // APB transfer; a read is compared with the expected value
    task automatic reg_access(logic wr, logic [1:0] idx, logic [31:0] wdata,
                              logic [31:0] rd_expected);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr) begin
            case (idx)
                REG_PREFETCH: cfg_pf   = wdata[0];
                REG_OFFSET:   cfg_ob   = wdata[3:0];
                REG_SETS:     cfg_sb   = wdata[3:0];
                default:      cfg_ways = wdata[3:0];
            endcase
        end else if (prdata !== rd_expected) begin
            $display("%0t: register %0d read expected %0h, got %0h",
                     $time, idx, rd_expected, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_item(t_in_item it, logic typed, logic hit, logic prefetched);
        t_out_item want;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        want = cache_access(it.action, it.address);
        if (typed) begin
            want.hit        = hit;
            want.prefetched = prefetched;
        end
        pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic stop_and_drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected, got %h",
                         $time, o_out_data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(o_out_data.hit));
                check_field("prefetched", 32'(want.prefetched), 32'(o_out_data.prefetched));
                check_field("read_count", want.read_count, o_out_data.read_count);
                check_field("write_count", want.write_count, o_out_data.write_count);
                check_field("hit_count", want.hit_count, o_out_data.hit_count);
                check_field("miss_count", want.miss_count, o_out_data.miss_count);
            end
        end
    end

    initial begin : stimulus
        t_in_item             it;
        logic                 pf_v;
        logic [3:0]           ob_v;
        logic [3:0]           sb_v;
        logic [3:0]           ways_v;
        logic [19:0]          shared_low;
        logic [ADDR_BITS-1:0] r48;
        int                   pause_at;

        cfg_pf       = 1'b0;
        cfg_ob       = 4'd6;
        cfg_sb       = 4'd6;
        cfg_ways     = 4'd8;
        total_reads  = '0;
        total_writes = '0;
        total_hits   = '0;
        total_misses = '0;
        for (int s = 0; s < NUM_SETS; s++) begin
            fifo_ptr[s] = '0;
            for (int w = 0; w < MAX_WAYS; w++) begin
                line_ok[s][w]      = 1'b0;
                line_tag_mem[s][w] = '0;
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < NUM_ROWS; k++) begin
            case (DIRECTED[k].kind)
                ROW_SET_REG: begin
                    stop_and_drain();
                    reg_access(1'b1, DIRECTED[k].idx, DIRECTED[k].value, '0);
                end
                ROW_GET_REG: begin
                    stop_and_drain();
                    reg_access(1'b0, DIRECTED[k].idx, '0, DIRECTED[k].value);
                end
                default: begin
                    it.action  = DIRECTED[k].action;
                    it.address = DIRECTED[k].address;
                    send_item(it, DIRECTED[k].typed, DIRECTED[k].hit, DIRECTED[k].prefetched);
                end
            endcase
        end

        // pool halves share their low bits so they collide in the same sets
        shared_low = 20'($urandom);
        for (int phase = 0; phase < PHASES; phase++) begin
            stop_and_drain();
            for (int i = 0; i < POOL_SIZE; i++) begin
                if (phase == 0 || $urandom_range(0, 1) == 1) begin
                    r48 = ADDR_BITS'({$urandom, $urandom});
                    addr_pool[i] = {r48[ADDR_BITS-1:20], (i % 2 == 1) ? shared_low : 20'h0};
                end
            end
            case (phase)
                0: begin pf_v = 1'b1; ob_v = 4'd12; sb_v = 4'd8; ways_v = 4'd8; end
                1: begin pf_v = 1'b0; ob_v = 4'd0; sb_v = 4'd0; ways_v = 4'd1; end
                2: begin pf_v = 1'b1; ob_v = 4'd15; sb_v = 4'd1; ways_v = 4'd2; end
                default: begin
                    pf_v   = 1'($urandom_range(0, 1));
                    ob_v   = 4'($urandom_range(0, 15));
                    sb_v   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                         : 4'($urandom_range(0, 3));
                    ways_v = 4'($urandom_range(0, 15));
                end
            endcase
            reg_access(1'b1, REG_PREFETCH, with_noise({31'd0, pf_v}, 32'h1), '0);
            reg_access(1'b1, REG_OFFSET, with_noise({28'd0, ob_v}, 32'hF), '0);
            reg_access(1'b1, REG_SETS, with_noise({28'd0, sb_v}, 32'hF), '0);
            reg_access(1'b1, REG_WAYS, with_noise({28'd0, ways_v}, 32'hF), '0);
            foreach (ALL_REGS[r]) reg_access(1'b0, ALL_REGS[r], '0, cfg_value(ALL_REGS[r]));

            quiet       = (phase == QUIET_PHASE);
            stream_addr = addr_pool[0];
            pause_at    = $urandom_range(20, PHASE_ITEMS - 20);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == pause_at) stop_and_drain();
                it.action  = ($urandom_range(0, 1) == 1) ? ACT_WRITE : ACT_READ;
                it.address = pick_address();
                send_item(it, 1'b0, 1'b0, 1'b0);
            end
        end

        quiet = 1'b0;
        stop_and_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
